[rtl/crpf_pkg.sv]
// Shared constants, codes and control types for the clipped rectangle pixel flag engine.
`default_nettype none

package crpf_pkg;

    // Field widths
    localparam int REQ_W    = 2;
    localparam int COORD_W  = 12;
    localparam int SIZE_W   = 10;
    localparam int VAL_W    = 8;
    localparam int CFG_W    = 10;
    localparam int PIX_W    = 10;   // pixel coordinate inside the active map
    localparam int CLIP_W   = 14;   // signed width for clip arithmetic

    // Stream packing
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = REQ_W;
    localparam int M_TDATA_W = 8;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;
    localparam logic [CFG_W-1:0]     MAP_SIZE_RESET = 10'd512;

    // Default map storage bounds
    localparam int MAP_W_MAX_DEF = 512;
    localparam int MAP_H_MAX_DEF = 512;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FILL  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_OR    = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CLIP,
        ST_CHECK,
        ST_RUN,
        ST_DRAIN,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic clip;
        logic start;
        logic run;
        logic respond;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic empty;
        logic last_pixel;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

[rtl/crpf_ctrl.sv]
// Controller state machine: sequences clear pass, clip, pixel sweep and result.
`default_nettype none

module crpf_ctrl
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire crpf_pkg::dp_status_t   status,
    output crpf_pkg::ctrl_cmd_t         cmd
);

    crpf_pkg::state_t state_reg;
    crpf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= crpf_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            crpf_pkg::ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = crpf_pkg::ST_IDLE;
                end
            end
            crpf_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = crpf_pkg::ST_CLIP;
                end
            end
            crpf_pkg::ST_CLIP:
            begin
                state_next = crpf_pkg::ST_CHECK;
            end
            crpf_pkg::ST_CHECK:
            begin
                state_next = status.empty ? crpf_pkg::ST_RESP : crpf_pkg::ST_RUN;
            end
            crpf_pkg::ST_RUN:
            begin
                if (status.last_pixel)
                begin
                    state_next = crpf_pkg::ST_DRAIN;
                end
            end
            crpf_pkg::ST_DRAIN:
            begin
                state_next = crpf_pkg::ST_RESP;
            end
            crpf_pkg::ST_RESP:
            begin
                if (status.out_free)
                begin
                    state_next = crpf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = crpf_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            crpf_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            crpf_pkg::ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            crpf_pkg::ST_CLIP:
            begin
                cmd.clip = 1'b1;
            end
            crpf_pkg::ST_CHECK:
            begin
                cmd.start = 1'b1;
            end
            crpf_pkg::ST_RUN:
            begin
                cmd.run = 1'b1;
            end
            crpf_pkg::ST_DRAIN:
            begin
                cmd = '0;
            end
            crpf_pkg::ST_RESP:
            begin
                cmd.respond = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/crpf_dp.sv]
// Datapath: config registers, clip logic, sweep counters, pixel memory, result register.
`default_nettype none

module crpf_dp
#(
    parameter int MAP_W_MAX = crpf_pkg::MAP_W_MAX_DEF,
    parameter int MAP_H_MAX = crpf_pkg::MAP_H_MAX_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // config write
    input  wire logic                              cfg_valid,
    input  wire logic [crpf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [crpf_pkg::CFG_W-1:0]        cfg_data,
    // request payload
    input  wire logic [crpf_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic [crpf_pkg::S_TUSER_W-1:0]    s_tuser,
    // result
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [crpf_pkg::M_TDATA_W-1:0]         m_tdata,
    // controller link
    input  wire crpf_pkg::ctrl_cmd_t               cmd,
    output crpf_pkg::dp_status_t                   status
);

    localparam int DEPTH  = MAP_W_MAX * MAP_H_MAX;
    localparam int AW     = $clog2(DEPTH);
    localparam int PW     = AW + crpf_pkg::CLIP_W;
    localparam int CW     = crpf_pkg::CLIP_W;
    localparam int XW     = crpf_pkg::PIX_W;
    localparam int VW     = crpf_pkg::VAL_W;
    localparam logic [AW-1:0] ADDR_LAST  = AW'(DEPTH - 1);
    localparam logic [AW-1:0] ROW_STRIDE = AW'(MAP_W_MAX);
    localparam logic [CW-1:0] W_MAX_C    = CW'(MAP_W_MAX);
    localparam logic [CW-1:0] H_MAX_C    = CW'(MAP_H_MAX);

    // ---------------- configuration ----------------
    logic [crpf_pkg::CFG_W-1:0] map_width_reg;
    logic [crpf_pkg::CFG_W-1:0] map_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= crpf_pkg::MAP_SIZE_RESET;
            map_height_reg <= crpf_pkg::MAP_SIZE_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == crpf_pkg::REG_MAP_WIDTH)
            begin
                map_width_reg <= cfg_data;
            end
            if (cfg_index == crpf_pkg::REG_MAP_HEIGHT)
            begin
                map_height_reg <= cfg_data;
            end
        end
    end

    // ---------------- request capture ----------------
    logic [crpf_pkg::REQ_W-1:0]   req_reg;
    logic [crpf_pkg::COORD_W-1:0] rx_reg;
    logic [crpf_pkg::COORD_W-1:0] ry_reg;
    logic [crpf_pkg::SIZE_W-1:0]  rw_reg;
    logic [crpf_pkg::SIZE_W-1:0]  rh_reg;
    logic [VW-1:0]                val_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= s_tuser;
            rx_reg  <= s_tdata[11:0];
            ry_reg  <= s_tdata[23:12];
            rw_reg  <= s_tdata[33:24];
            rh_reg  <= s_tdata[43:34];
            val_reg <= s_tdata[51:44];
        end
    end

    // ---------------- clip ----------------
    logic signed [CW-1:0] rx_e, ry_e, rw_e, rh_e, xe, ye, bw, bh;
    logic [CW-1:0]        mw_u, mh_u;
    logic signed [CW-1:0] x1_next, x2_next, y1_next, y2_next;
    logic signed [CW-1:0] x1_reg, x2_reg, y1_reg, y2_reg;

    always_comb
    begin
        rx_e = {{(CW - crpf_pkg::COORD_W){rx_reg[crpf_pkg::COORD_W-1]}}, rx_reg};
        ry_e = {{(CW - crpf_pkg::COORD_W){ry_reg[crpf_pkg::COORD_W-1]}}, ry_reg};
        rw_e = {{(CW - crpf_pkg::SIZE_W){1'b0}}, rw_reg};
        rh_e = {{(CW - crpf_pkg::SIZE_W){1'b0}}, rh_reg};
        mw_u = {{(CW - crpf_pkg::CFG_W){1'b0}}, map_width_reg};
        mh_u = {{(CW - crpf_pkg::CFG_W){1'b0}}, map_height_reg};
        bw   = (mw_u > W_MAX_C) ? W_MAX_C : mw_u;
        bh   = (mh_u > H_MAX_C) ? H_MAX_C : mh_u;
        xe   = rx_e + rw_e;
        ye   = ry_e + rh_e;
        x1_next = rx_e[CW-1] ? '0 : rx_e;
        y1_next = ry_e[CW-1] ? '0 : ry_e;
        x2_next = (xe < bw) ? xe : bw;
        y2_next = (ye < bh) ? ye : bh;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clip)
        begin
            x1_reg <= x1_next;
            x2_reg <= x2_next;
            y1_reg <= y1_next;
            y2_reg <= y2_next;
        end
    end

    // ---------------- sweep counters ----------------
    logic [XW-1:0]        x_first_reg, x_last_reg, y_last_reg;
    logic [XW-1:0]        x_cnt_reg, x_cnt_next;
    logic [XW-1:0]        y_cnt_reg, y_cnt_next;
    logic [AW-1:0]        row_base_reg, row_base_next;
    logic signed [CW-1:0] x2_m1, y2_m1;
    logic [PW-1:0]        row_prod;
    logic [AW-1:0]        run_addr;
    logic                 row_end;

    always_comb
    begin
        x2_m1      = x2_reg - CW'(1);
        y2_m1      = y2_reg - CW'(1);
        row_prod   = PW'(unsigned'(y1_reg)) * PW'(MAP_W_MAX);
        run_addr   = row_base_reg + AW'(x_cnt_reg);
        row_end    = (x_cnt_reg == x_last_reg);
        x_cnt_next    = x_cnt_reg;
        y_cnt_next    = y_cnt_reg;
        row_base_next = row_base_reg;
        if (cmd.start)
        begin
            x_cnt_next    = x1_reg[XW-1:0];
            y_cnt_next    = y1_reg[XW-1:0];
            row_base_next = row_prod[AW-1:0];
        end
        else if (cmd.run)
        begin
            if (row_end)
            begin
                x_cnt_next    = x_first_reg;
                y_cnt_next    = y_cnt_reg + XW'(1);
                row_base_next = row_base_reg + ROW_STRIDE;
            end
            else
            begin
                x_cnt_next = x_cnt_reg + XW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            x_first_reg <= x1_reg[XW-1:0];
            x_last_reg  <= x2_m1[XW-1:0];
            y_last_reg  <= y2_m1[XW-1:0];
        end
        x_cnt_reg    <= x_cnt_next;
        y_cnt_reg    <= y_cnt_next;
        row_base_reg <= row_base_next;
    end

    // ---------------- clear pass address ----------------
    logic [AW-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    // ---------------- pixel memory and read-modify-write stage ----------------
    logic [VW-1:0] pixel_mem [DEPTH];
    logic [VW-1:0] rd_data_reg;
    logic          pipe_valid_reg;
    logic [AW-1:0] pipe_addr_reg;
    logic          is_query, is_fill, is_or;
    logic          we;
    logic [AW-1:0] wa;
    logic [VW-1:0] wd;

    always_comb
    begin
        is_query = (req_reg == crpf_pkg::REQ_QUERY);
        is_fill  = (req_reg == crpf_pkg::REQ_FILL);
        is_or    = (req_reg == crpf_pkg::REQ_OR);
        we = 1'b0;
        wa = pipe_addr_reg;
        wd = rd_data_reg | val_reg;
        priority if (cmd.clear_step)
        begin
            we = 1'b1;
            wa = clr_addr_reg;
            wd = '0;
        end
        else if (cmd.run && is_fill)
        begin
            we = 1'b1;
            wa = run_addr;
            wd = val_reg;
        end
        else if (pipe_valid_reg && is_or)
        begin
            we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            pixel_mem[wa] <= wd;
        end
        rd_data_reg <= pixel_mem[run_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_valid_reg <= 1'b0;
        end
        else
        begin
            pipe_valid_reg <= cmd.run && (is_query || is_or);
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_addr_reg <= run_addr;
    end

    // ---------------- accumulator ----------------
    logic [VW-1:0] acc_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            acc_reg <= '0;
        end
        else if (pipe_valid_reg && is_query)
        begin
            acc_reg <= acc_reg | rd_data_reg;
        end
    end

    // ---------------- result register ----------------
    logic          out_valid_reg;
    logic [VW-1:0] flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.respond)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.respond)
        begin
            flags_reg <= is_query ? acc_reg : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = flags_reg;

    // ---------------- status ----------------
    always_comb
    begin
        status.clear_last = (clr_addr_reg == ADDR_LAST);
        status.empty      = (x2_reg <= x1_reg) || (y2_reg <= y1_reg);
        status.last_pixel = row_end && (y_cnt_reg == y_last_reg);
        status.out_free   = !out_valid_reg || m_tready;
    end

endmodule

`default_nettype wire

[rtl/clipped_rect_pixel_flag_engine.sv]
// Top level of the clipped rectangle pixel flag engine: ports, controller and datapath.
`default_nettype none

// The block keeps a byte-per-pixel flag map of MAP_W_MAX x MAP_H_MAX bytes in a
// single-port-write, registered-read memory; pixel (x,y) sits at y*MAP_W_MAX+x.
// After reset a clearing pass writes zero to every byte, one per cycle; no
// request is taken until it finishes, while config writes are taken at any
// time. Each request names a rectangle that is clipped against map_width and
// map_height (each capped at the storage bound). A query ORs every byte inside,
// a fill writes pixel_value, an OR request sets bits; the block then returns
// one result transfer (flags_found, zero except for a query; tlast always high).
// A request passes capture, clip and check, then a sweep with one memory access
// per cycle over the clipped rectangle, a drain state for the registered read
// and the result load; an empty rectangle skips the sweep and the drain. The
// result sits in an output register, so the next request is taken while an
// earlier result waits to be transferred. Configure only while the block is
// idle.

module clipped_rect_pixel_flag_engine
#(
    parameter int MAP_W_MAX = crpf_pkg::MAP_W_MAX_DEF,
    parameter int MAP_H_MAX = crpf_pkg::MAP_H_MAX_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // config write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [crpf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [crpf_pkg::CFG_W-1:0]        cfg_data,
    // request stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // rect_x[11:0], rect_y[23:12], rect_w[33:24], rect_h[43:34],
    // pixel_value[51:44], zero[55:52]
    input  wire logic [crpf_pkg::S_TDATA_W-1:0]    s_tdata,
    // req_type[1:0]
    input  wire logic [crpf_pkg::S_TUSER_W-1:0]    s_tuser,
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // flags_found[7:0]
    output logic [crpf_pkg::M_TDATA_W-1:0]         m_tdata,
    // done_res
    output logic                                   m_tlast
);

    crpf_pkg::ctrl_cmd_t  cmd;
    crpf_pkg::dp_status_t status;

    // Registers are plain flops; a write is always taken.
    assign cfg_ready = 1'b1;
    // Every request yields exactly one result, so each result closes its request.
    assign m_tlast   = 1'b1;

    crpf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    crpf_dp
    #(
        .MAP_W_MAX (MAP_W_MAX),
        .MAP_H_MAX (MAP_H_MAX)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

[tb/crpf_checker.sv]
// Passive checker: mirrors the flag map, predicts every result and compares each transfer.
`timescale 1ns / 100ps

module crpf_checker
    import crpf_pkg::*;
#(
    parameter int MAP_W_MAX = MAP_W_MAX_DEF,
    parameter int MAP_H_MAX = MAP_H_MAX_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [S_TDATA_W-1:0]    s_tdata,
    input  logic [S_TUSER_W-1:0]    s_tuser,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [M_TDATA_W-1:0]    m_tdata,
    input  logic                    m_tlast,
    output int                      fail_count,
    output int                      owed_count
);

    typedef struct packed {
        logic [VAL_W-1:0] flags;
        logic             done;
    } result_t;

    logic [VAL_W-1:0] flag_map [MAP_W_MAX*MAP_H_MAX];
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    result_t          owed_results [$];

    // map is cleared once; reset is only applied at the start of the run
    initial
    begin
        foreach (flag_map[i])
            flag_map[i] = '0;
    end

    // Clip the rectangle to the active map and apply the request to the mirror.
    task automatic sweep_rect(
        input  logic [REQ_W-1:0]          op,
        input  logic signed [COORD_W-1:0] rx,
        input  logic signed [COORD_W-1:0] ry,
        input  logic [SIZE_W-1:0]         rw,
        input  logic [SIZE_W-1:0]         rh,
        input  logic [VAL_W-1:0]          value,
        output logic [VAL_W-1:0]          found
    );
        int bw, bh, sx, sy, sw, sh, x1, y1, x2, y2, addr;
        bw = (int'(width_reg) > MAP_W_MAX) ? MAP_W_MAX : int'(width_reg);
        bh = (int'(height_reg) > MAP_H_MAX) ? MAP_H_MAX : int'(height_reg);
        sx = int'(rx);
        sy = int'(ry);
        sw = int'(rw);
        sh = int'(rh);
        x1 = (sx < 0) ? 0 : sx;
        y1 = (sy < 0) ? 0 : sy;
        x2 = (sx + sw < bw) ? sx + sw : bw;
        y2 = (sy + sh < bh) ? sy + sh : bh;
        found = '0;
        for (int y = y1; y < y2; y++)
        begin
            for (int x = x1; x < x2; x++)
            begin
                // fixed row stride, independent of the active width
                addr = y * MAP_W_MAX + x;
                case (op)
                    REQ_QUERY: found = found | flag_map[addr];
                    REQ_FILL:  flag_map[addr] = value;
                    REQ_OR:    flag_map[addr] = flag_map[addr] | value;
                    default:   ;
                endcase
            end
        end
        if (op != REQ_QUERY)
            found = '0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [VAL_W-1:0] found;
        result_t          due;
        if (!rst_n)
        begin
            width_reg  = MAP_SIZE_RESET;
            height_reg = MAP_SIZE_RESET;
            owed_results.delete();
            fail_count = 0;
            owed_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MAP_WIDTH:  width_reg = cfg_data;
                    REG_MAP_HEIGHT: height_reg = cfg_data;
                    default:        ;
                endcase
            end
            // result first: a result never belongs to a request taken at the same edge
            if (m_tvalid && m_tready)
            begin
                if (owed_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, got flags %02h last %b",
                             $time, m_tdata, m_tlast);
                end
                else
                begin
                    due = owed_results.pop_front();
                    if (m_tdata !== due.flags)
                    begin
                        fail_count++;
                        $display("%0t: flags_found mismatch, expected %02h, got %02h",
                                 $time, due.flags, m_tdata);
                    end
                    if (m_tlast !== due.done)
                    begin
                        fail_count++;
                        $display("%0t: done_res mismatch, expected %b, got %b",
                                 $time, due.done, m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                sweep_rect(s_tuser, s_tdata[11:0], s_tdata[23:12], s_tdata[33:24],
                           s_tdata[43:34], s_tdata[51:44], found);
                due.flags = found;
                due.done  = 1'b1;
                owed_results.push_back(due);
            end
            owed_count = owed_results.size();
        end
    end

endmodule

[tb/tb_clipped_rect_pixel_flag_engine.sv]
// Top of the pixel flag engine testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module tb_clipped_rect_pixel_flag_engine;
    import crpf_pkg::*;

    // Register indexes the block does not decode; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    // Request code with no operation behind it.
    localparam logic [REQ_W-1:0]     REQ_UNUSED  = 2'd3;

    localparam int IDLE_PCT     = 35;       // chance of an idle cycle on either side
    localparam int HOLD_CYCLES  = 3000;     // long receiver hold-off
    localparam int SEGMENTS     = 6;        // random phases, one map size each
    localparam int SEG_ITEMS    = 255;
    localparam int AREA_CAP     = 1024;     // pixel budget of one noise request
    localparam int DRAIN_GAP    = 8;        // settle time before a register write
    localparam int TAIL_CYCLES  = 32;
    // Clearing pass plus every request at its pixel budget, stalled on both
    // sides, taken several times over.
    localparam int LIMIT_CYCLES = 8_000_000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    int fail_count;
    int owed_count;
    int cycle_count = 0;

    // Shared with the result sink; written at the falling edge, sampled by the
    // sink at the rising edge so that no ordering within a step matters.
    bit steady_flow = 1'b0;
    bit hold_request = 1'b0;

    // Effective map size as last written, used only to aim the stimulus.
    int map_w_eff = MAP_W_MAX_DEF;
    int map_h_eff = MAP_H_MAX_DEF;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    clipped_rect_pixel_flag_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    crpf_checker result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .owed_count (owed_count)
    );

    function automatic bit take_break(input bit calm);
        return !calm && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    // Width of [origin, origin+len) left after clipping to [0, bound).
    function automatic int clipped_span(input int origin, input int len, input int bound);
        int lo, hi;
        lo = (origin < 0) ? 0 : origin;
        hi = (origin + len < bound) ? origin + len : bound;
        return (hi > lo) ? hi - lo : 0;
    endfunction

    // Offer one request, with random idle cycles ahead of it, and wait for its
    // transfer. Called and returns at a falling edge; tvalid stays high so
    // back-to-back requests need no gap.
    task automatic issue(input logic [REQ_W-1:0] op, input int x, input int y, input int w,
                         input int h, input int value);
        logic [COORD_W-1:0] px, py;
        logic [SIZE_W-1:0]  pw, ph;
        logic [VAL_W-1:0]   pv;
        px = x[COORD_W-1:0];
        py = y[COORD_W-1:0];
        pw = w[SIZE_W-1:0];
        ph = h[SIZE_W-1:0];
        pv = value[VAL_W-1:0];
        while (take_break(steady_flow))
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        // pad, pixel_value, rect_h, rect_w, rect_y, rect_x (lowest)
        s_tdata  = {4'b0, pv, ph, pw, py, px};
        s_tuser  = op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // One register transfer; valid is dropped for a cycle afterwards.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value[CFG_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        @(negedge clk);
    endtask

    // Stop offering and wait until every owed result has come back.
    task automatic wait_idle;
        s_tvalid = 1'b0;
        while (owed_count != 0)
            @(negedge clk);
        repeat (DRAIN_GAP)
            @(negedge clk);
    endtask

    task automatic resize_map(input int w, input int h);
        wait_idle();
        write_register(REG_MAP_WIDTH, w);
        write_register(REG_MAP_HEIGHT, h);
        map_w_eff = (w > MAP_W_MAX_DEF) ? MAP_W_MAX_DEF : w;
        map_h_eff = (h > MAP_H_MAX_DEF) ? MAP_H_MAX_DEF : h;
    endtask

    // Result side: random ready, one long hold-off on request, calm stretches
    // follow the sender.
    initial
    begin : result_sink
        bit held, launch, calm;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            launch = hold_request && !held;
            calm   = steady_flow;
            @(negedge clk);
            if (launch)
            begin
                held     = 1'b1;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES)
                    @(negedge clk);
            end
            m_tready = !take_break(calm);
        end
    end

    initial
    begin : watchdog
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [REQ_W-1:0] op;
        int x, y, w, h, value, pick, hot;
        int seg_w [SEGMENTS];
        int seg_h [SEGMENTS];

        seg_w = '{512, 64, 1023, 1, 300, 0};
        seg_h = '{512, 48, 200, 512, 1, 0};

        repeat (4)
            @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset map size (no write yet). The block is in
        // its clearing pass first; the first transfer simply waits for it.
        issue(REQ_FILL, 0, 0, 4, 4, 'hFF);
        issue(REQ_QUERY, -2048, -2048, 1023, 1023, 'h00);   // far off the low corner
        issue(REQ_QUERY, 0, 0, 1, 1, 'h00);
        issue(REQ_OR, 2047, 2047, 1023, 1023, 'h55);        // far off the high corner
        issue(REQ_QUERY, -3, -3, 5, 5, 'h00);               // clipped on the left and top
        issue(REQ_FILL, 2, 2, 0, 7, 'h00);                  // zero width
        issue(REQ_OR, 0, 0, 5, 0, 'hFF);                    // zero height
        issue(REQ_QUERY, 500, 500, 1023, 1023, 'h00);       // clipped on the right and bottom
        issue(REQ_FILL, 505, 505, 1023, 1023, 'hA5);
        issue(REQ_OR, 510, 510, 2, 2, 'h5A);
        issue(REQ_QUERY, 511, 511, 1, 1, 'h00);
        issue(REQ_UNUSED, 0, 0, 4, 4, 'h12);                // must leave the map alone
        issue(REQ_QUERY, 0, 0, 4, 4, 'hFF);
        issue(REQ_OR, -1, 1, 3, 2, 'h00);
        issue(REQ_FILL, 1, 1, 2, 2, 'h3C);

        // oversized registers act as the storage bound
        resize_map(1023, 1023);
        issue(REQ_QUERY, 508, 508, 10, 10, 'h00);

        // zero width: every rectangle is empty
        resize_map(0, 300);
        issue(REQ_FILL, 0, 0, 10, 10, 'h77);
        issue(REQ_QUERY, 0, 0, 8, 8, 'h00);

        // single-pixel map, then grow it again: hidden bytes come back
        resize_map(1, 1);
        issue(REQ_QUERY, -5, -5, 100, 100, 'h00);
        issue(REQ_FILL, 0, 0, 3, 3, 'h01);
        resize_map(4, 4);
        write_register(REG_SPARE_A, 1023);
        write_register(REG_SPARE_B, 0);
        issue(REQ_QUERY, 0, 0, 4, 4, 'h00);
        issue(REQ_QUERY, 1, 1, 3, 3, 'h00);

        // Random part, one map size per segment. Most requests hit a small hot
        // window or the far edge so fills, ORs and queries overlap; the rest is
        // full-range noise with its clipped area kept within budget.
        seg_w[SEGMENTS-1] = int'($urandom_range(0, 1023));
        seg_h[SEGMENTS-1] = int'($urandom_range(1, 1023));
        for (int s = 0; s < SEGMENTS; s++)
        begin
            resize_map(seg_w[s], seg_h[s]);
            write_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                           int'($urandom_range(0, 1023)));
            for (int i = 0; i < SEG_ITEMS; i++)
            begin
                if (s == 1 && i == 40)
                    hold_request = 1'b1;     // result side stalls, input must back up
                steady_flow = (s == 3) && (i >= 50) && (i < 200);
                pick = int'($urandom_range(0, 99));
                if (pick < 85)
                begin
                    pick = int'($urandom_range(0, 9));
                    op = (pick < 4) ? REQ_QUERY : (pick < 7) ? REQ_OR :
                         (pick < 9) ? REQ_FILL : REQ_UNUSED;
                    hot = (map_w_eff < 40) ? map_w_eff : 40;
                    x = ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, hot + 6)) - 6 :
                        map_w_eff - 12 + int'($urandom_range(0, 16));
                    hot = (map_h_eff < 40) ? map_h_eff : 40;
                    y = ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, hot + 6)) - 6 :
                        map_h_eff - 12 + int'($urandom_range(0, 16));
                    w = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 32)) :
                        int'($urandom_range(0, 12));
                    h = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 32)) :
                        int'($urandom_range(0, 12));
                    // single flag bits make OR accumulation visible to queries
                    value = $urandom_range(0, 1) ? (1 << $urandom_range(0, 7)) :
                            int'($urandom_range(0, 255));
                end
                else
                begin
                    op    = REQ_W'($urandom_range(0, 3));
                    x     = int'($urandom_range(0, 4095)) - 2048;
                    y     = int'($urandom_range(0, 4095)) - 2048;
                    w     = int'($urandom_range(0, 1023));
                    h     = int'($urandom_range(0, 1023));
                    value = int'($urandom_range(0, 255));
                    if (clipped_span(x, w, map_w_eff) * clipped_span(y, h, map_h_eff)
                            > AREA_CAP)
                    begin
                        if ($urandom_range(0, 1))
                            h = int'($urandom_range(0, 2));
                        else
                            w = int'($urandom_range(0, 2));
                    end
                end
                issue(op, x, y, w, h, value);
            end
        end
        steady_flow = 1'b0;

        // drain, then let the block sit for a while to catch stray transfers
        wait_idle();
        repeat (TAIL_CYCLES)
            @(negedge clk);

        if (fail_count == 0 && owed_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
